// ===== sv/led_strip_effect_generator_unit_defines.svh =====
// Assertion macros shared by the LED strip effect generator modules.
`ifndef LED_STRIP_EFFECT_GENERATOR_UNIT_DEFINES_SVH
`define LED_STRIP_EFFECT_GENERATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, idle during reset.
`define LSEG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lseg: same-cycle check failed");
// Next-cycle implication, sampled on clk, idle during reset.
`define LSEG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lseg: next-cycle check failed");
`else
`define LSEG_ASSERT_IMP(lbl, ante, cons)
`define LSEG_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== sv/lseg_pkg.sv =====
// Types, constants and helper functions of the LED strip effect generator.
package lseg_pkg;

  localparam int unsigned POS_W = 6;
  localparam int unsigned RGB_W = 24;

  localparam logic [2:0] MODE_FILL     = 3'd0;
  localparam logic [2:0] MODE_METEOR   = 3'd1;
  localparam logic [2:0] MODE_ACC_FWD  = 3'd2;
  localparam logic [2:0] MODE_ACC_REV  = 3'd3;
  localparam logic [2:0] MODE_BREATH   = 3'd4;

  localparam logic [1:0] REG_MODE     = 2'd0;
  localparam logic [1:0] REG_FILL     = 2'd1;
  localparam logic [1:0] REG_LEAD     = 2'd2;
  localparam logic [1:0] REG_BACKDROP = 2'd3;

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_RUN_A = 2'd1;
  localparam logic [1:0] PH_RUN_B = 2'd2;
  localparam logic [1:0] PH_IDLE  = 2'd3;

  localparam logic [POS_W-1:0] DELAY_RESTART = 6'd10;
  localparam logic [POS_W-1:0] DELAY_METEOR  = 6'd50;
  localparam logic [POS_W-1:0] DELAY_ACC     = 6'd30;
  localparam logic [POS_W-1:0] DELAY_BREATH  = 6'd2;

  localparam logic [2:0] RAMP_LEN = 3'd5;

  typedef enum logic [2:0] {
    FR_FILL    = 3'd0,
    FR_METEOR  = 3'd1,
    FR_ACC_FWD = 3'd2,
    FR_ACC_REV = 3'd3,
    FR_BR_RISE = 3'd4,
    FR_BR_FALL = 3'd5
  } frame_kind_t;

  typedef enum logic [1:0] {
    BR_HOLD  = 2'd0,
    BR_CLEAR = 2'd1,
    BR_UP    = 2'd2,
    BR_DOWN  = 2'd3
  } breath_op_t;

  typedef struct packed {
    logic              frame_start;
    frame_kind_t       kind;
    logic [POS_W-1:0]  pos;
    breath_op_t        bop;
  } dp_cmd_t;

  typedef struct packed {
    logic gen_busy;
    logic up_at_target;
    logic down_at_zero;
  } dp_stat_t;

  // Step each channel one count toward the target.
  function automatic logic [RGB_W-1:0] breath_up(logic [RGB_W-1:0] c, logic [RGB_W-1:0] t);
    logic [RGB_W-1:0] r;
    r = c;
    for (int i = 0; i < 3; i++) begin
      if (c[i*8 +: 8] < t[i*8 +: 8]) begin
        r[i*8 +: 8] = c[i*8 +: 8] + 8'd1;
      end
    end
    return r;
  endfunction

  // Step each channel one count toward black.
  function automatic logic [RGB_W-1:0] breath_down(logic [RGB_W-1:0] c);
    logic [RGB_W-1:0] r;
    r = c;
    for (int i = 0; i < 3; i++) begin
      if (c[i*8 +: 8] != 8'd0) begin
        r[i*8 +: 8] = c[i*8 +: 8] - 8'd1;
      end
    end
    return r;
  endfunction

  // Grey ramp of the meteor head, dim to bright.
  function automatic logic [RGB_W-1:0] meteor_ramp(logic [2:0] k);
    logic [RGB_W-1:0] r;
    unique case (k)
      3'd0:    r = 24'h323232;
      3'd1:    r = 24'h646464;
      3'd2:    r = 24'h969696;
      3'd3:    r = 24'hC8C8C8;
      3'd4:    r = 24'hFFFFFF;
      default: r = 24'h000000;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/lseg_ctrl.sv =====
// Controller: request sequencing and effect phase, delay and position state.
`include "led_strip_effect_generator_unit_defines.svh"
module lseg_ctrl
  import lseg_pkg::*;
#(
  parameter int unsigned LED_COUNT = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_restart,
  input  logic        in_tick,
  input  logic [2:0]  effect_mode,
  input  dp_stat_t    stat,
  output dp_cmd_t     cmd
);

  localparam logic [POS_W:0] LED_N    = (POS_W+1)'(LED_COUNT);
  localparam logic [POS_W:0] METEOR_N = (POS_W+1)'(LED_COUNT - 5);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_STEP = 3'b010,
    ST_EMIT = 3'b100
  } ctrl_state_t;

  ctrl_state_t       state_r, state_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [POS_W-1:0]  delay_r, delay_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              restart_r, tick_r;
  logic [1:0]        ph_w;
  logic [POS_W-1:0]  dly_w;
  logic [POS_W-1:0]  pos_inc;

  assign in_ready = (state_r == ST_IDLE);
  assign pos_inc  = pos_r + 6'd1;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    delay_nxt = delay_r;
    pos_nxt   = pos_r;
    ph_w      = restart_r ? PH_START : phase_r;
    dly_w     = restart_r ? DELAY_RESTART : delay_r;
    cmd       = '{frame_start: 1'b0, kind: FR_FILL, pos: pos_r, bop: BR_HOLD};
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        unique case (effect_mode)
          MODE_FILL: begin
            if (ph_w == PH_START) begin
              if (dly_w == '0) begin
                ph_w = PH_RUN_A;
              end
            end else if (ph_w == PH_RUN_A) begin
              cmd.frame_start = 1'b1;
              cmd.kind        = FR_FILL;
              ph_w            = PH_IDLE;
            end
          end
          MODE_METEOR: begin
            if (dly_w == '0) begin
              if (ph_w == PH_START) begin
                pos_nxt = '0;
                ph_w    = PH_RUN_A;
              end else if (ph_w == PH_RUN_A) begin
                cmd.frame_start = 1'b1;
                cmd.kind        = FR_METEOR;
                pos_nxt         = pos_inc;
                if ({1'b0, pos_inc} > METEOR_N) begin
                  ph_w = PH_START;
                end
                dly_w = DELAY_METEOR;
              end
            end
          end
          MODE_ACC_FWD, MODE_ACC_REV: begin
            if (dly_w == '0) begin
              if (ph_w == PH_START) begin
                pos_nxt = '0;
                ph_w    = (effect_mode == MODE_ACC_FWD) ? PH_RUN_A : PH_RUN_B;
              end else if (ph_w == PH_RUN_A || ph_w == PH_RUN_B) begin
                // direction follows the phase, not the mode
                cmd.frame_start = 1'b1;
                cmd.kind        = (ph_w == PH_RUN_A) ? FR_ACC_FWD : FR_ACC_REV;
                pos_nxt         = pos_inc;
                if ({1'b0, pos_inc} > LED_N) begin
                  ph_w = PH_IDLE;
                end
                dly_w = DELAY_ACC;
              end
            end
          end
          MODE_BREATH: begin
            if (dly_w == '0) begin
              if (ph_w == PH_START) begin
                cmd.bop = BR_CLEAR;
                ph_w    = PH_RUN_A;
              end else if (ph_w == PH_RUN_A) begin
                cmd.frame_start = 1'b1;
                cmd.kind        = FR_BR_RISE;
                cmd.bop         = BR_UP;
                if (stat.up_at_target) begin
                  ph_w = PH_RUN_B;
                end
                dly_w = DELAY_BREATH;
              end else if (ph_w == PH_RUN_B) begin
                cmd.frame_start = 1'b1;
                cmd.kind        = FR_BR_FALL;
                cmd.bop         = BR_DOWN;
                if (stat.down_at_zero) begin
                  ph_w = PH_IDLE;
                end
                dly_w = DELAY_BREATH;
              end
            end
          end
          default: begin
          end
        endcase
        if (tick_r && dly_w != '0) begin
          dly_w = dly_w - 6'd1;
        end
        phase_nxt = ph_w;
        delay_nxt = dly_w;
        state_nxt = cmd.frame_start ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!stat.gen_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_START;
      delay_r <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      delay_r <= delay_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      restart_r <= in_restart;
      tick_r    <= in_tick;
    end
  end

  `LSEG_ASSERT_IMP(a_start_in_step, cmd.frame_start, state_r == ST_STEP)
  `LSEG_ASSERT_IMP(a_delay_bound, 1'b1, delay_r <= DELAY_METEOR)
  `LSEG_ASSERT_IMP(a_idle_silent, state_r == ST_STEP && phase_r == PH_IDLE && !restart_r, !cmd.frame_start)

endmodule

// ===== sv/lseg_datapath.sv =====
// Datapath: breathing color, frame descriptor, pixel generator and output register.
`include "led_strip_effect_generator_unit_defines.svh"
module lseg_datapath
  import lseg_pkg::*;
#(
  parameter int unsigned LED_COUNT = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic [RGB_W-1:0]  fill_color,
  input  logic [RGB_W-1:0]  lead_color,
  input  logic [RGB_W-1:0]  backdrop_color,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [RGB_W-1:0]  out_data,
  output logic              out_last
);

  localparam logic [POS_W:0] LED_N = (POS_W+1)'(LED_COUNT);

  logic [RGB_W-1:0]  breath_r, breath_nxt;
  logic [RGB_W-1:0]  breath_inc, breath_dec;
  frame_kind_t       kind_r;
  logic [POS_W-1:0]  fpos_r;
  logic [RGB_W-1:0]  fcolor_r;
  logic              gen_active_r, gen_active_nxt;
  logic [POS_W-1:0]  pix_r, pix_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [RGB_W-1:0]  out_data_r;
  logic              out_last_r;

  logic              pos_on_strip;
  logic [POS_W:0]    frame_len, lit, pix_ext, ofs;
  logic              pix_last, load;
  logic [RGB_W-1:0]  pix_color;

  assign breath_inc = breath_up(breath_r, lead_color);
  assign breath_dec = breath_down(breath_r);

  assign stat = '{gen_busy:     gen_active_r,
                  up_at_target: (breath_inc == lead_color),
                  down_at_zero: (breath_dec == '0)};

  always_comb begin
    unique case (cmd.bop)
      BR_HOLD:  breath_nxt = breath_r;
      BR_CLEAR: breath_nxt = '0;
      BR_UP:    breath_nxt = breath_inc;
      BR_DOWN:  breath_nxt = breath_dec;
      default:  breath_nxt = breath_r;
    endcase
  end

  // Frame geometry from the latched position.
  assign pos_on_strip = ({1'b0, fpos_r} < LED_N);
  assign frame_len    = (kind_r == FR_METEOR && pos_on_strip) ? LED_N + 7'd4 : LED_N;
  assign lit          = pos_on_strip ? {1'b0, fpos_r} : LED_N;
  assign pix_ext      = {1'b0, pix_r};
  assign ofs          = pix_ext - {1'b0, fpos_r};
  assign pix_last     = (pix_ext == frame_len - 7'd1);

  always_comb begin
    unique case (kind_r)
      FR_FILL, FR_BR_RISE, FR_BR_FALL: pix_color = fcolor_r;
      FR_METEOR: begin
        if (pos_on_strip && pix_r >= fpos_r && ofs < {4'd0, RAMP_LEN}) begin
          pix_color = meteor_ramp(ofs[2:0]);
        end else begin
          pix_color = '0;
        end
      end
      FR_ACC_FWD: pix_color = (pix_ext < lit) ? lead_color : backdrop_color;
      FR_ACC_REV: pix_color = (pix_ext < LED_N - lit) ? backdrop_color : lead_color;
      default:    pix_color = '0;
    endcase
  end

  assign load = gen_active_r && (!out_valid_r || out_ready);

  always_comb begin
    gen_active_nxt = gen_active_r;
    pix_nxt        = pix_r;
    if (cmd.frame_start) begin
      gen_active_nxt = 1'b1;
      pix_nxt        = '0;
    end else if (load) begin
      pix_nxt = pix_r + 6'd1;
      if (pix_last) begin
        gen_active_nxt = 1'b0;
      end
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      breath_r     <= '0;
      gen_active_r <= 1'b0;
      pix_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      breath_r     <= breath_nxt;
      gen_active_r <= gen_active_nxt;
      pix_r        <= pix_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.frame_start) begin
      kind_r   <= cmd.kind;
      fpos_r   <= cmd.pos;
      // rising frames show the color before the step, falling ones after
      unique case (cmd.kind)
        FR_BR_RISE: fcolor_r <= breath_r;
        FR_BR_FALL: fcolor_r <= breath_dec;
        default:    fcolor_r <= fill_color;
      endcase
    end
    if (load) begin
      out_data_r <= pix_color;
      out_last_r <= pix_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

  `LSEG_ASSERT_IMP(a_no_overlap, cmd.frame_start, !gen_active_r)
  `LSEG_ASSERT_IMP(a_pix_bound, gen_active_r, pix_ext < frame_len)
  `LSEG_ASSERT_NXT(a_last_stops, load && pix_last, !gen_active_r && out_last_r)

endmodule

// ===== sv/led_strip_effect_generator_unit.sv =====
// Top level of the LED strip effect generator: ports, register file, controller and datapath.
//
// Channel  Direction  Handshake             Payload
// in_      slave      in_tvalid/in_tready   tdata[0] restart, tdata[1] tick
// out_     master     out_tvalid/out_tready tdata green/red/blue, tlast last pixel
// cfg_     slave      cfg_valid/cfg_ready   cfg_index register, cfg_data value
//
// Each request is accepted and then stepped by the controller; a request that starts
// a frame then holds the input off until the last pixel reaches the output register.
// A frame is LED_COUNT pixels, LED_COUNT+4 for a meteor frame with its head on the
// strip, generated one per cycle while the output is not stalled. Output stalls hold
// the pixel generator; the output register keeps the last pixel while the next
// request is taken. Reset is synchronous, active low, and clears the effect state
// and the registers; there is no clearing pass.
`include "led_strip_effect_generator_unit_defines.svh"
module led_strip_effect_generator_unit
  import lseg_pkg::*;
#(
  parameter int unsigned LED_COUNT = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [0] restart, [1] tick, [7:2] zero
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [23:0]  out_tdata,  // [7:0] green, [15:8] red, [23:16] blue
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [23:0]  cfg_data
);

  logic [2:0]        mode_r;
  logic [RGB_W-1:0]  fill_r, lead_r, back_r;
  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [RGB_W-1:0]  pix_rgb;
  logic              cfg_wr;

  // Register writes are always accepted.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_FILL;
      fill_r <= '0;
      lead_r <= '0;
      back_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_MODE:     mode_r <= cfg_data[2:0];
        REG_FILL:     fill_r <= cfg_data;
        REG_LEAD:     lead_r <= cfg_data;
        REG_BACKDROP: back_r <= cfg_data;
        default:      mode_r <= mode_r;
      endcase
    end
  end

  // Sequence requests and the effect phase.
  lseg_ctrl #(
    .LED_COUNT (LED_COUNT)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_restart  (in_tdata[0]),
    .in_tick     (in_tdata[1]),
    .effect_mode (mode_r),
    .stat        (stat),
    .cmd         (cmd)
  );

  // Generate pixels of the commanded frame.
  lseg_datapath #(
    .LED_COUNT (LED_COUNT)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .fill_color     (fill_r),
    .lead_color     (lead_r),
    .backdrop_color (back_r),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_data       (pix_rgb),
    .out_last       (out_tlast)
  );

  // Reorder to strip byte order: green first, then red, then blue.
  assign out_tdata = {pix_rgb[7:0], pix_rgb[23:16], pix_rgb[15:8]};

  `LSEG_ASSERT_IMP(a_frame_needs_ready, cmd.frame_start, !out_tvalid || !stat.gen_busy)
  `LSEG_ASSERT_NXT(a_start_sets_busy, cmd.frame_start, stat.gen_busy)
  `LSEG_ASSERT_IMP(a_no_accept_busy, in_tvalid && in_tready, !stat.gen_busy)

endmodule
